### rtl/lcahl_pkg.sv
// Shared types and constants for the heavy-light lowest-common-ancestor engine.
// No dependencies; every other file imports this package.
package lcahl_pkg;

    localparam int MAX_NODES_DEF      = 1024;
    localparam int MAX_EDGE_SLOTS_DEF = 2048;
    localparam int ROOT_NODE          = 1;

    localparam int OP_W   = 2;
    localparam int NODE_W = 11;
    localparam int STAT_W = 2;

    typedef enum logic [OP_W-1:0] {
        OP_ADD   = 2'd0,
        OP_BUILD = 2'd1,
        OP_QUERY = 2'd2
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_RANGE   = 2'd2,
        ST_UNBUILT = 2'd3
    } stat_t;

    typedef enum logic [5:0] {
        S_CLR_HEAD, S_IDLE,
        S_ADD0, S_ADD1, S_ADD2, S_ADD3,
        S_BCLR, S_BINIT, S_BHEAD,
        S_WTOP, S_WEDGE, S_WCHK, S_WPUSH,
        S_POP1, S_POP2, S_POP3,
        S_CH0, S_CH1, S_CH2, S_CH3,
        S_Q0, S_Q1, S_Q2,
        S_QT0, S_QT1, S_QT2, S_QD1, S_QD2, S_QP, S_QE1, S_QE2,
        S_DONE
    } state_t;

endpackage

### rtl/lcahl_req_if.sv
// Request channel: valid/ready handshake carrying op, node_a and node_b.
// Depends on lcahl_pkg for the field widths.
interface lcahl_req_if import lcahl_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   op;
    logic [NODE_W-1:0] node_a;
    logic [NODE_W-1:0] node_b;

    modport source (output valid, op, node_a, node_b, input ready);
    modport sink   (input valid, op, node_a, node_b, output ready);
endinterface

### rtl/lcahl_rsp_if.sv
// Response channel: valid/ready handshake carrying ancestor and status.
// Depends on lcahl_pkg for the field widths.
interface lcahl_rsp_if import lcahl_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [NODE_W-1:0] ancestor;
    logic [STAT_W-1:0] status;

    modport source (output valid, ancestor, status, input ready);
    modport sink   (input valid, ancestor, status, output ready);
endinterface

### rtl/lcahl_alu.sv
// Shared add and compare unit used by the walk and query sequencer.
// Depends on lcahl_pkg for MAX_NODES_DEF, which sets the default width.
module lcahl_alu import lcahl_pkg::*; #(
    parameter int W = $clog2(MAX_NODES_DEF + 1)
) (
    input  logic [W-1:0] a,
    input  logic [W-1:0] b,
    output logic [W-1:0] sum,
    output logic         lt
);
    // Sizes never exceed the node count, so the sum fits in W bits.
    assign sum = a + b;
    assign lt  = (a < b);
endmodule

### rtl/tree_lca_heavy_light_core.sv
// Top level of the heavy-light lowest-common-ancestor engine: sequencer and memories.
// Depends on lcahl_pkg, lcahl_req_if, lcahl_rsp_if and lcahl_alu.
//
//   Channel  Dir  Payload                Item
//   req      in   op, node_a, node_b     one add, build or query command
//   rsp      out  ancestor, status       one result for every request item
//
// After reset the adjacency heads are swept to the empty marker, one entry a cycle,
// with req.ready low. An add reads and links each of its two slots, a rejected item goes
// straight to its result, and a query reads both depths, then hops chains until the tops match.
// A build clears the depth memory, scans the edge slots of each node it reaches, then
// makes the chain pass over the reached nodes in preorder;
// every step waits on one registered memory read.
// A finished result sits in the output register while the next item is accepted;
// only a second finished result waits for rsp.ready.
module tree_lca_heavy_light_core import lcahl_pkg::*; #(
    parameter int MAX_NODES      = MAX_NODES_DEF,
    parameter int MAX_EDGE_SLOTS = MAX_EDGE_SLOTS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    lcahl_req_if.sink    req,
    lcahl_rsp_if.source  rsp
);
    localparam int NW = $clog2(MAX_NODES + 1);        // node number, depth, size
    localparam int EW = $clog2(MAX_EDGE_SLOTS + 1);   // edge slot or empty marker
    localparam int XW = (MAX_EDGE_SLOTS > 1) ? $clog2(MAX_EDGE_SLOTS) : 1;
    localparam int KW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int SW = NW + EW;
    localparam logic [EW-1:0] NO_EDGE = EW'(MAX_EDGE_SLOTS);
    localparam logic [NW-1:0] ROOT    = NW'(ROOT_NODE);
    localparam logic [NW-1:0] ONE     = NW'(1);

    // Memories. Each has one write port and one registered read port.
    logic [EW-1:0] head_mem [0:MAX_NODES];
    logic [NW-1:0] etgt_mem [0:MAX_EDGE_SLOTS-1];
    logic [EW-1:0] enxt_mem [0:MAX_EDGE_SLOTS-1];
    logic [NW-1:0] par_mem  [0:MAX_NODES];
    logic [NW-1:0] dep_mem  [0:MAX_NODES];
    logic [NW-1:0] size_mem [0:MAX_NODES];
    logic [NW-1:0] hvy_mem  [0:MAX_NODES];
    logic [NW-1:0] top_mem  [0:MAX_NODES];
    logic [SW-1:0] stk_mem  [0:MAX_NODES-1];
    logic [NW-1:0] walk_mem [0:MAX_NODES-1];

    logic          h_we, t_we, x_we, p_we, d_we, z_we, v_we, c_we, s_we, w_we;
    logic [NW-1:0] h_wa, h_ra, p_wa, p_ra, d_wa, d_ra, z_wa, z_ra;
    logic [NW-1:0] v_wa, v_ra, c_wa, c_ra;
    logic [XW-1:0] t_wa, t_ra, x_wa, x_ra;
    logic [KW-1:0] s_wa, s_ra, w_wa, w_ra;
    logic [EW-1:0] h_wd, h_rd, x_wd, x_rd;
    logic [NW-1:0] t_wd, t_rd, p_wd, p_rd, d_wd, d_rd, z_wd, z_rd;
    logic [NW-1:0] v_wd, v_rd, c_wd, c_rd, w_wd, w_rd;
    logic [SW-1:0] s_wd, s_rd;

    always_ff @(posedge clk)
    begin
        if (h_we) head_mem[h_wa] <= h_wd;
        if (t_we) etgt_mem[t_wa] <= t_wd;
        if (x_we) enxt_mem[x_wa] <= x_wd;
        if (p_we) par_mem[p_wa]  <= p_wd;
        if (d_we) dep_mem[d_wa]  <= d_wd;
        if (z_we) size_mem[z_wa] <= z_wd;
        if (v_we) hvy_mem[v_wa]  <= v_wd;
        if (c_we) top_mem[c_wa]  <= c_wd;
        if (s_we) stk_mem[s_wa]  <= s_wd;
        if (w_we) walk_mem[w_wa] <= w_wd;
        h_rd <= head_mem[h_ra];
        t_rd <= etgt_mem[t_ra];
        x_rd <= enxt_mem[x_ra];
        p_rd <= par_mem[p_ra];
        d_rd <= dep_mem[d_ra];
        z_rd <= size_mem[z_ra];
        v_rd <= hvy_mem[v_ra];
        c_rd <= top_mem[c_ra];
        s_rd <= stk_mem[s_ra];
        w_rd <= walk_mem[w_ra];
    end

    // Sequencer registers.
    state_t        state_reg, state_next;
    logic [NW-1:0] clr_reg, clr_next;
    logic [EW-1:0] ec_reg, ec_next;
    logic          built_reg, built_next;
    logic [NW-1:0] a_reg, a_next, b_reg, b_next;
    logic [NW-1:0] u_reg, u_next, v_reg, v_next;
    logic [EW-1:0] cur_reg, cur_next;
    logic [NW-1:0] sp_reg, sp_next, vis_reg, vis_next, i_reg, i_next;
    logic [NW-1:0] p_reg, p_next, su_reg, su_next;
    logic [NW-1:0] tu_reg, tu_next, tv_reg, tv_next, dl_reg, dl_next;
    logic          side_reg, side_next, miss_reg, miss_next;
    logic [NW-1:0] res_anc_reg, res_anc_next;
    stat_t         res_stat_reg, res_stat_next;
    logic          rsp_valid_reg, rsp_valid_next;
    logic [NODE_W-1:0] rsp_anc_reg, rsp_anc_next;
    stat_t         rsp_stat_reg, rsp_stat_next;

    // Shared add/compare unit.
    logic [NW-1:0] alu_a, alu_b, alu_sum;
    logic          alu_lt;

    lcahl_alu #(.W(NW)) u_alu (
        .a   (alu_a),
        .b   (alu_b),
        .sum (alu_sum),
        .lt  (alu_lt)
    );

    logic          in_ok;
    logic [EW-1:0] ec_one;
    logic          v_in_range;

    assign in_ok = (req.node_a != '0) && (32'(req.node_a) <= 32'(MAX_NODES))
                && (req.node_b != '0) && (32'(req.node_b) <= 32'(MAX_NODES));
    assign ec_one     = ec_reg + EW'(1);
    assign v_in_range = (v_reg != '0) && (32'(v_reg) <= 32'(MAX_NODES));

    assign req.ready    = (state_reg == S_IDLE);
    assign rsp.valid    = rsp_valid_reg;
    assign rsp.ancestor = rsp_anc_reg;
    assign rsp.status   = rsp_stat_reg;

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        ec_next        = ec_reg;
        built_next     = built_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        u_next         = u_reg;
        v_next         = v_reg;
        cur_next       = cur_reg;
        sp_next        = sp_reg;
        vis_next       = vis_reg;
        i_next         = i_reg;
        p_next         = p_reg;
        su_next        = su_reg;
        tu_next        = tu_reg;
        tv_next        = tv_reg;
        dl_next        = dl_reg;
        side_next      = side_reg;
        miss_next      = miss_reg;
        res_anc_next   = res_anc_reg;
        res_stat_next  = res_stat_reg;
        rsp_valid_next = rsp_valid_reg && !rsp.ready;
        rsp_anc_next   = rsp_anc_reg;
        rsp_stat_next  = rsp_stat_reg;

        alu_a = su_reg;
        alu_b = dl_reg;

        h_we = 1'b0; h_wa = '0; h_wd = '0; h_ra = '0;
        t_we = 1'b0; t_wa = '0; t_wd = '0; t_ra = '0;
        x_we = 1'b0; x_wa = '0; x_wd = '0; x_ra = '0;
        p_we = 1'b0; p_wa = '0; p_wd = '0; p_ra = '0;
        d_we = 1'b0; d_wa = '0; d_wd = '0; d_ra = '0;
        z_we = 1'b0; z_wa = '0; z_wd = '0; z_ra = '0;
        v_we = 1'b0; v_wa = '0; v_wd = '0; v_ra = '0;
        c_we = 1'b0; c_wa = '0; c_wd = '0; c_ra = '0;
        s_we = 1'b0; s_wa = '0; s_wd = '0; s_ra = '0;
        w_we = 1'b0; w_wa = '0; w_wd = '0; w_ra = '0;

        case (state_reg)
            S_CLR_HEAD:
            begin
                h_we = 1'b1; h_wa = clr_reg; h_wd = NO_EDGE;
                clr_next = clr_reg + ONE;
                if (clr_reg == NW'(MAX_NODES))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req.valid)
                begin
                    a_next       = NW'(req.node_a);
                    b_next       = NW'(req.node_b);
                    res_anc_next = '0;
                    res_stat_next = ST_OK;
                    state_next   = S_DONE;
                    case (op_t'(req.op))
                        OP_ADD:
                        begin
                            if (!in_ok)
                            begin
                                res_stat_next = ST_RANGE;
                            end
                            else if (32'(ec_reg) + 32'd2 > 32'(MAX_EDGE_SLOTS))
                            begin
                                res_stat_next = ST_FULL;
                            end
                            else
                            begin
                                state_next = S_ADD0;
                            end
                        end
                        OP_BUILD:
                        begin
                            clr_next   = '0;
                            state_next = S_BCLR;
                        end
                        OP_QUERY:
                        begin
                            if (!in_ok)
                            begin
                                res_stat_next = ST_RANGE;
                            end
                            else if (!built_reg)
                            begin
                                res_stat_next = ST_UNBUILT;
                            end
                            else
                            begin
                                state_next = S_Q0;
                            end
                        end
                        default:
                        begin
                            res_stat_next = ST_OK;
                        end
                    endcase
                end
            end

            // Edge insert: two slots, each linked in at the front of its node's list.
            S_ADD0:
            begin
                h_ra = a_reg;
                state_next = S_ADD1;
            end
            S_ADD1:
            begin
                t_we = 1'b1; t_wa = ec_reg[XW-1:0]; t_wd = b_reg;
                x_we = 1'b1; x_wa = ec_reg[XW-1:0]; x_wd = h_rd;
                h_we = 1'b1; h_wa = a_reg; h_wd = ec_reg;
                state_next = S_ADD2;
            end
            S_ADD2:
            begin
                h_ra = b_reg;
                state_next = S_ADD3;
            end
            S_ADD3:
            begin
                t_we = 1'b1; t_wa = ec_one[XW-1:0]; t_wd = a_reg;
                x_we = 1'b1; x_wa = ec_one[XW-1:0]; x_wd = h_rd;
                h_we = 1'b1; h_wa = b_reg; h_wd = ec_one;
                ec_next    = ec_reg + EW'(2);
                built_next = 1'b0;
                state_next = S_DONE;
            end

            // Build: clear depth, seed the root, then walk with an explicit stack.
            // The top of the stack lives in u_reg/cur_reg; its depth equals sp_reg.
            S_BCLR:
            begin
                d_we = 1'b1; d_wa = clr_reg; d_wd = '0;
                clr_next = clr_reg + ONE;
                if (clr_reg == NW'(MAX_NODES))
                begin
                    state_next = S_BINIT;
                end
            end
            S_BINIT:
            begin
                d_we = 1'b1; d_wa = ROOT; d_wd = ONE;
                z_we = 1'b1; z_wa = ROOT; z_wd = ONE;
                p_we = 1'b1; p_wa = ROOT; p_wd = '0;
                v_we = 1'b1; v_wa = ROOT; v_wd = '0;
                w_we = 1'b1; w_wa = '0;   w_wd = ROOT;
                h_ra = ROOT;
                u_next   = ROOT;
                vis_next = ONE;
                sp_next  = ONE;
                state_next = S_BHEAD;
            end
            S_BHEAD:
            begin
                cur_next   = h_rd;
                state_next = S_WTOP;
            end
            S_WTOP:
            begin
                if (cur_reg != NO_EDGE)
                begin
                    t_ra = cur_reg[XW-1:0];
                    x_ra = cur_reg[XW-1:0];
                    state_next = S_WEDGE;
                end
                else
                begin
                    p_ra = u_reg;
                    z_ra = u_reg;
                    state_next = S_POP1;
                end
            end
            S_WEDGE:
            begin
                v_next   = t_rd;
                cur_next = x_rd;
                d_ra     = t_rd;
                state_next = S_WCHK;
            end
            S_WCHK:
            begin
                state_next = S_WTOP;
                if (v_in_range && (d_rd == '0) && (32'(sp_reg) < 32'(MAX_NODES))
                    && (32'(vis_reg) < 32'(MAX_NODES)))
                begin
                    p_we = 1'b1; p_wa = v_reg; p_wd = u_reg;
                    d_we = 1'b1; d_wa = v_reg; d_wd = sp_reg + ONE;
                    z_we = 1'b1; z_wa = v_reg; z_wd = ONE;
                    v_we = 1'b1; v_wa = v_reg; v_wd = '0;
                    w_we = 1'b1; w_wa = vis_reg[KW-1:0]; w_wd = v_reg;
                    s_we = 1'b1; s_wa = KW'(sp_reg - ONE); s_wd = {u_reg, cur_reg};
                    h_ra = v_reg;
                    vis_next   = vis_reg + ONE;
                    state_next = S_WPUSH;
                end
            end
            S_WPUSH:
            begin
                u_next   = v_reg;
                cur_next = h_rd;
                sp_next  = sp_reg + ONE;
                state_next = S_WTOP;
            end

            // Pop: fold the finished child's size into its parent and update heavy child.
            S_POP1:
            begin
                p_next  = p_rd;
                su_next = z_rd;
                v_next  = u_reg;
                sp_next = sp_reg - ONE;
                if (p_rd == '0)
                begin
                    i_next     = '0;
                    state_next = S_CH0;
                end
                else
                begin
                    z_ra = p_rd;
                    v_ra = p_rd;
                    s_ra = KW'(sp_reg - NW'(2));
                    state_next = S_POP2;
                end
            end
            S_POP2:
            begin
                alu_a = z_rd;
                alu_b = su_reg;
                z_we = 1'b1; z_wa = p_reg; z_wd = alu_sum;
                u_next   = s_rd[SW-1:EW];
                cur_next = s_rd[EW-1:0];
                if (v_rd == '0)
                begin
                    v_we = 1'b1; v_wa = p_reg; v_wd = v_reg;
                    state_next = S_WTOP;
                end
                else
                begin
                    z_ra = v_rd;
                    state_next = S_POP3;
                end
            end
            S_POP3:
            begin
                alu_a = z_rd;
                alu_b = su_reg;
                if (alu_lt)
                begin
                    v_we = 1'b1; v_wa = p_reg; v_wd = v_reg;
                end
                state_next = S_WTOP;
            end

            // Chain pass in preorder: a heavy child inherits its parent's chain top.
            S_CH0:
            begin
                if (i_reg == vis_reg)
                begin
                    built_next = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    w_ra = i_reg[KW-1:0];
                    state_next = S_CH1;
                end
            end
            S_CH1:
            begin
                v_next = w_rd;
                p_ra   = w_rd;
                state_next = S_CH2;
            end
            S_CH2:
            begin
                if (p_rd == '0)
                begin
                    c_we = 1'b1; c_wa = v_reg; c_wd = v_reg;
                    i_next     = i_reg + ONE;
                    state_next = S_CH0;
                end
                else
                begin
                    v_ra = p_rd;
                    c_ra = p_rd;
                    state_next = S_CH3;
                end
            end
            S_CH3:
            begin
                c_we = 1'b1; c_wa = v_reg;
                c_wd = (v_rd == v_reg) ? c_rd : v_reg;
                i_next     = i_reg + ONE;
                state_next = S_CH0;
            end

            // Query: reject unreached nodes, then hop the deeper chain until tops match.
            S_Q0:
            begin
                d_ra = a_reg;
                state_next = S_Q1;
            end
            S_Q1:
            begin
                miss_next = (d_rd == '0);
                d_ra = b_reg;
                state_next = S_Q2;
            end
            S_Q2:
            begin
                if (miss_reg || (d_rd == '0))
                begin
                    res_stat_next = ST_RANGE;
                    state_next    = S_DONE;
                end
                else
                begin
                    u_next = a_reg;
                    v_next = b_reg;
                    state_next = S_QT0;
                end
            end
            S_QT0:
            begin
                c_ra = u_reg;
                state_next = S_QT1;
            end
            S_QT1:
            begin
                tu_next = c_rd;
                c_ra = v_reg;
                state_next = S_QT2;
            end
            S_QT2:
            begin
                tv_next = c_rd;
                if (tu_reg == c_rd)
                begin
                    d_ra = u_reg;
                    state_next = S_QE1;
                end
                else
                begin
                    d_ra = tu_reg;
                    state_next = S_QD1;
                end
            end
            S_QD1:
            begin
                dl_next = d_rd;
                d_ra = tv_reg;
                state_next = S_QD2;
            end
            S_QD2:
            begin
                // Compare depth of v's chain top against u's.
                alu_a = d_rd;
                alu_b = dl_reg;
                side_next = alu_lt;
                p_ra = alu_lt ? tu_reg : tv_reg;
                state_next = S_QP;
            end
            S_QP:
            begin
                if (side_reg)
                begin
                    u_next = p_rd;
                end
                else
                begin
                    v_next = p_rd;
                end
                state_next = S_QT0;
            end
            S_QE1:
            begin
                dl_next = d_rd;
                d_ra = v_reg;
                state_next = S_QE2;
            end
            S_QE2:
            begin
                alu_a = d_rd;
                alu_b = dl_reg;
                res_anc_next = alu_lt ? v_reg : u_reg;
                state_next   = S_DONE;
            end

            // Hand the result to the output register once it is free.
            S_DONE:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_anc_next   = NODE_W'(res_anc_reg);
                    rsp_stat_next  = res_stat_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR_HEAD;
            clr_reg       <= '0;
            ec_reg        <= '0;
            built_reg     <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            ec_reg        <= ec_next;
            built_reg     <= built_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg        <= a_next;
        b_reg        <= b_next;
        u_reg        <= u_next;
        v_reg        <= v_next;
        cur_reg      <= cur_next;
        sp_reg       <= sp_next;
        vis_reg      <= vis_next;
        i_reg        <= i_next;
        p_reg        <= p_next;
        su_reg       <= su_next;
        tu_reg       <= tu_next;
        tv_reg       <= tv_next;
        dl_reg       <= dl_next;
        side_reg     <= side_next;
        miss_reg     <= miss_next;
        res_anc_reg  <= res_anc_next;
        res_stat_reg <= res_stat_next;
        rsp_anc_reg  <= rsp_anc_next;
        rsp_stat_reg <= rsp_stat_next;
    end

endmodule
